// ===== rtl/mrgja_pkg.sv =====
// Package for the MRG32k3a jump-ahead block: payload structs, moduli,
// jump matrices and pipeline constants. No dependencies.
`default_nettype none

package mrgja_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic  func;
        t_word kind_tag;
        t_word m1_seed_0;
        t_word m1_seed_1;
        t_word m1_seed_2;
        t_word m2_seed_0;
        t_word m2_seed_1;
        t_word m2_seed_2;
    } t_req;

    typedef struct packed {
        t_word kind_tag_out;
        t_word m1_next_0;
        t_word m1_next_1;
        t_word m1_next_2;
        t_word m2_next_0;
        t_word m2_next_1;
        t_word m2_next_2;
    } t_rsp;

    // Jump selector codes
    localparam logic FUNC_STREAM    = 1'b0;  // 2^127 steps
    localparam logic FUNC_SUBSTREAM = 1'b1;  // 2^76 steps

    localparam int NUM_COMP = 2;
    localparam int DIM      = 3;
    localparam int STAGES   = 5;

    // Moduli, and 2^32 - modulus, used to fold the high half back in
    localparam t_word       MOD  [NUM_COMP] = '{32'd4294967087, 32'd4294944443};
    localparam logic [14:0] FOLD [NUM_COMP] = '{15'd209, 15'd22853};

    // JMP[func][component][row][col]
    localparam t_word JMP [2][NUM_COMP][DIM][DIM] = '{
        '{  // next stream
            '{ '{32'd2427906178, 32'd3580155704, 32'd949770784 },
               '{32'd226153695,  32'd1230515664, 32'd3580155704},
               '{32'd1988835001, 32'd986791581,  32'd1230515664} },
            '{ '{32'd1464411153, 32'd277697599,  32'd1610723613},
               '{32'd32183930,   32'd1464411153, 32'd1022607788},
               '{32'd2824425944, 32'd32183930,   32'd2093834863} }
        },
        '{  // next substream
            '{ '{32'd82758667,   32'd1871391091, 32'd4127413238},
               '{32'd3672831523, 32'd69195019,   32'd1871391091},
               '{32'd3672091415, 32'd3528743235, 32'd69195019  } },
            '{ '{32'd1511326704, 32'd3759209742, 32'd1610795712},
               '{32'd4292754251, 32'd1511326704, 32'd3889917532},
               '{32'd3859662829, 32'd4292754251, 32'd3708466080} }
        }
    };

    // Per-stage load enables
    typedef struct packed {
        logic [STAGES-1:0] en;
    } t_pipe_ctl;

endpackage

`default_nettype wire

// ===== rtl/mrgja_ctrl.sv =====
// Pipeline flow control for the jump-ahead datapath: per-stage valid bits
// and load enables. Depends on mrgja_pkg.
`default_nettype none

module mrgja_ctrl import mrgja_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_pipe_ctl o_ctl
);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] en;

    // A stage loads when it is empty or its contents move on this cycle
    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            if (en[k]) begin
                n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready   = en[0];
    assign o_valid   = r_vld[STAGES-1];
    assign o_ctl.en  = en;

endmodule

`default_nettype wire

// ===== rtl/mrgja_datapath.sv =====
// Five-stage arithmetic of the jump: products, two modular folds, row sums,
// final reduction. Depends on mrgja_pkg.
`default_nettype none

module mrgja_datapath import mrgja_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_pipe_ctl i_ctl,
    input  wire t_req      i_req,
    output t_rsp           o_rsp
);

    t_word        seed   [NUM_COMP][DIM];

    logic [63:0]  prod_d [NUM_COMP][DIM][DIM];
    logic [47:0]  f1_d   [NUM_COMP][DIM][DIM];
    logic [32:0]  f2_x   [NUM_COMP][DIM][DIM];
    t_word        res_d  [NUM_COMP][DIM][DIM];
    logic [33:0]  sum_d  [NUM_COMP][DIM];
    t_word        out_d  [NUM_COMP][DIM];

    logic [63:0]  r_prod [NUM_COMP][DIM][DIM];
    logic [47:0]  r_f1   [NUM_COMP][DIM][DIM];
    t_word        r_res  [NUM_COMP][DIM][DIM];
    logic [33:0]  r_sum  [NUM_COMP][DIM];
    t_word        r_out  [NUM_COMP][DIM];
    t_word        r_tag  [STAGES];

    assign seed[0][0] = i_req.m1_seed_0;
    assign seed[0][1] = i_req.m1_seed_1;
    assign seed[0][2] = i_req.m1_seed_2;
    assign seed[1][0] = i_req.m2_seed_0;
    assign seed[1][1] = i_req.m2_seed_1;
    assign seed[1][2] = i_req.m2_seed_2;

    always_comb begin
        for (int g = 0; g < NUM_COMP; g++) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    prod_d[g][r][c] = 64'(JMP[i_req.func][g][r][c]) * 64'(seed[g][c]);
                    // hi*2^32 + lo == hi*fold + lo (mod m)
                    f1_d[g][r][c] = 48'(r_prod[g][r][c][63:32]) * 48'(FOLD[g])
                                  + 48'(r_prod[g][r][c][31:0]);
                    // second fold lands below 2m
                    f2_x[g][r][c] = 33'(r_f1[g][r][c][47:32]) * 33'(FOLD[g])
                                  + 33'(r_f1[g][r][c][31:0]);
                    if (f2_x[g][r][c] >= 33'(MOD[g])) begin
                        res_d[g][r][c] = 32'(f2_x[g][r][c] - 33'(MOD[g]));
                    end else begin
                        res_d[g][r][c] = f2_x[g][r][c][31:0];
                    end
                end
                sum_d[g][r] = 34'(r_res[g][r][0]) + 34'(r_res[g][r][1])
                            + 34'(r_res[g][r][2]);
                // row sum is below 3m
                priority if (r_sum[g][r] >= 34'({MOD[g], 1'b0})) begin
                    out_d[g][r] = 32'(r_sum[g][r] - 34'({MOD[g], 1'b0}));
                end else if (r_sum[g][r] >= 34'(MOD[g])) begin
                    out_d[g][r] = 32'(r_sum[g][r] - 34'(MOD[g]));
                end else begin
                    out_d[g][r] = r_sum[g][r][31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_prod   <= prod_d;
            r_tag[0] <= i_req.kind_tag;
        end
        if (i_ctl.en[1]) begin
            r_f1     <= f1_d;
            r_tag[1] <= r_tag[0];
        end
        if (i_ctl.en[2]) begin
            r_res    <= res_d;
            r_tag[2] <= r_tag[1];
        end
        if (i_ctl.en[3]) begin
            r_sum    <= sum_d;
            r_tag[3] <= r_tag[2];
        end
        if (i_ctl.en[4]) begin
            r_out    <= out_d;
            r_tag[4] <= r_tag[3];
        end
    end

    assign o_rsp.kind_tag_out = r_tag[STAGES-1];
    assign o_rsp.m1_next_0    = r_out[0][0];
    assign o_rsp.m1_next_1    = r_out[0][1];
    assign o_rsp.m1_next_2    = r_out[0][2];
    assign o_rsp.m2_next_0    = r_out[1][0];
    assign o_rsp.m2_next_1    = r_out[1][1];
    assign o_rsp.m2_next_2    = r_out[1][2];

endmodule

`default_nettype wire

// ===== rtl/mrg_stream_jump_ahead.sv =====
// Top level of the MRG32k3a jump-ahead block: flow control plus datapath.
// Depends on mrgja_pkg, mrgja_ctrl and mrgja_datapath.
`default_nettype none

// Jumps a six-word MRG32k3a state ahead by 2^127 steps (func = 0, next
// stream) or 2^76 steps (func = 1, next substream); kind_tag is copied
// through. Fully pipelined: one request per cycle while the output is not
// stalled. Five register stages; output valid rises once a request has
// passed all five. The stages are the 18 parallel 32x32 products, two
// folds of each product by 2^32 - modulus, the row sums, and the last
// reduction into the output register. Each stage holds when it is full and
// its successor is full and stalled, so bubbles are squeezed out under
// backpressure. No state is kept between requests.
module mrg_stream_jump_ahead import mrgja_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_rsp      o_rsp
);

    t_pipe_ctl ctl;

    mrgja_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_ctl   (ctl)
    );

    mrgja_datapath u_dp (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_req (i_req),
        .o_rsp (o_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/mrgja_checker.sv =====
// Port-level checks for mrg_stream_jump_ahead, bound to the top level.
// Depends on mrgja_pkg.
`default_nettype none

module mrgja_checker import mrgja_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire t_req i_req,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_rsp o_rsp
);

    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    // items in flight
    always_comb begin
        n_cnt = r_cnt + 3'(i_valid && o_ready) - 3'(o_valid && i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_req))
        else $error("input transfer dropped or changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("output transfer dropped or changed while stalled");

    a_m1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.m1_next_0 < MOD[0] && o_rsp.m1_next_1 < MOD[0]
                    && o_rsp.m1_next_2 < MOD[0])
        else $error("first component not reduced");

    a_m2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.m2_next_0 < MOD[1] && o_rsp.m2_next_1 < MOD[1]
                    && o_rsp.m2_next_2 < MOD[1])
        else $error("second component not reduced");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || r_cnt != 3'd0) && (r_cnt <= 3'(STAGES)))
        else $error("output without matching input, or too many in flight");

endmodule

bind mrg_stream_jump_ahead mrgja_checker u_chk (.*);

`default_nettype wire
